@@ rtl/lockstep_link_frame_sync_defines.svh @@
// assertion macros for the lockstep link frame sync block
`ifndef LOCKSTEP_LINK_FRAME_SYNC_DEFINES_SVH
`define LOCKSTEP_LINK_FRAME_SYNC_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LLFS_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("llfs same-cycle check failed");

// next-cycle implication, checked out of reset
`define LLFS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("llfs next-cycle check failed");

`endif

@@ rtl/llfs_pkg.sv @@
// shared types and constants for the lockstep link frame sync block
`timescale 1ns / 1ps

package llfs_pkg;

   localparam int unsigned PACKET_BYTES = 4;
   localparam int unsigned STORE_DEPTH  = PACKET_BYTES - 1;

   localparam logic [7:0]  START_DATA      = 8'hFA;
   localparam logic [7:0]  START_NACK      = 8'hFB;
   localparam logic [15:0] TIMEOUT_DEFAULT = 16'd1000;
   localparam logic [15:0] IDLE_MAX        = 16'hFFFF;

   typedef enum logic [1:0] {
      REQ_RX_BYTE = 2'd0,
      REQ_BUTTONS = 2'd1,
      REQ_TICK    = 2'd2,
      REQ_UNUSED  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      KIND_TX         = 2'd0,
      KIND_REMOTE     = 2'd1,
      KIND_CSUM_ERR   = 2'd2,
      KIND_STRAY_NACK = 2'd3
   } out_kind_type;

   // everything one input item gives: an optional report followed by an optional packet
   typedef struct packed {
      logic                              has_lead;
      out_kind_type                      lead_kind;
      logic [7:0]                        lead_buttons;
      logic                              has_pkt;
      logic [PACKET_BYTES-1:0][7:0]      pkt;
      logic [7:0]                        frame;
   } run_type;

endpackage

@@ rtl/llfs_core.sv @@
// link state, packet gathering and the per-item decision
`timescale 1ns / 1ps

module llfs_core
   import llfs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [15:0]  csr_wr_data,
   input  logic         take,
   input  req_kind_type item_type,
   input  logic [7:0]   item_byte,
   input  logic [7:0]   item_buttons,
   output run_type      run,
   output logic         run_valid
);

   logic [15:0] timeout_ff;
   logic [7:0]  frame_ff, frame_in;
   logic [7:0]  own_ff, own_in;
   logic [7:0]  prev_own_ff, prev_own_in;
   logic [7:0]  rx_store_ff [STORE_DEPTH];
   logic [1:0]  rx_count_ff, rx_count_in;
   logic        waiting_ff, waiting_in;
   logic [15:0] idle_ff, idle_in;

   logic        store_we;
   logic [7:0]  expect_sum;
   logic [7:0]  prev_frame;
   logic [15:0] idle_inc;
   logic        send;
   logic [7:0]  send_start, send_frame, send_payload;

   assign expect_sum = rx_store_ff[0] + rx_store_ff[1] + rx_store_ff[2];
   assign prev_frame = frame_ff - 8'd1;
   assign idle_inc   = (idle_ff != IDLE_MAX) ? idle_ff + 16'd1 : idle_ff;

   always_comb begin
      frame_in     = frame_ff;
      own_in       = own_ff;
      prev_own_in  = prev_own_ff;
      rx_count_in  = rx_count_ff;
      waiting_in   = waiting_ff;
      idle_in      = idle_ff;
      store_we     = 1'b0;
      send         = 1'b0;
      send_start   = START_NACK;
      send_frame   = frame_ff;
      send_payload = 8'd0;
      run.has_lead     = 1'b0;
      run.lead_kind    = KIND_TX;
      run.lead_buttons = 8'd0;

      case (item_type)
         REQ_RX_BYTE: begin
            if (rx_count_ff == 2'd0 && item_byte != START_DATA && item_byte != START_NACK) begin
               // hunting for a start byte
            end else if (rx_count_ff != 2'(STORE_DEPTH)) begin
               store_we    = 1'b1;
               rx_count_in = rx_count_ff + 2'd1;
            end else begin
               rx_count_in = 2'd0;
               if (item_byte != expect_sum) begin
                  run.has_lead  = 1'b1;
                  run.lead_kind = KIND_CSUM_ERR;
                  send          = 1'b1;
               end else begin
                  idle_in = 16'd0;
                  if (rx_store_ff[0] == START_DATA) begin
                     if (rx_store_ff[1] == frame_ff) begin
                        run.has_lead     = 1'b1;
                        run.lead_kind    = KIND_REMOTE;
                        run.lead_buttons = rx_store_ff[2];
                        frame_in         = frame_ff + 8'd1;
                        waiting_in       = 1'b0;
                     end else begin
                        send = 1'b1;
                     end
                  end else if (rx_store_ff[1] == frame_ff) begin
                     send         = 1'b1;
                     send_start   = START_DATA;
                     send_payload = own_ff;
                  end else if (rx_store_ff[1] == prev_frame) begin
                     send         = 1'b1;
                     send_start   = START_DATA;
                     send_frame   = prev_frame;
                     send_payload = prev_own_ff;
                  end else begin
                     run.has_lead  = 1'b1;
                     run.lead_kind = KIND_STRAY_NACK;
                  end
               end
            end
         end
         REQ_BUTTONS: begin
            prev_own_in  = own_ff;
            own_in       = item_buttons;
            waiting_in   = 1'b1;
            send         = 1'b1;
            send_start   = START_DATA;
            send_payload = item_buttons;
         end
         REQ_TICK: begin
            idle_in = idle_inc;
            if (waiting_ff && idle_inc > timeout_ff) begin
               send = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // any packet sent restarts the idle count
      if (send) begin
         idle_in = 16'd0;
      end

      run.has_pkt = send;
      run.pkt[0]  = send_start;
      run.pkt[1]  = send_frame;
      run.pkt[2]  = send_payload;
      run.pkt[3]  = send_start + send_frame + send_payload;
      run.frame   = frame_in;
   end

   assign run_valid = run.has_lead | run.has_pkt;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff  <= TIMEOUT_DEFAULT;
         frame_ff    <= 8'd0;
         own_ff      <= 8'd0;
         prev_own_ff <= 8'd0;
         rx_count_ff <= 2'd0;
         waiting_ff  <= 1'b0;
         idle_ff     <= 16'd0;
      end else begin
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
         if (take) begin
            frame_ff    <= frame_in;
            own_ff      <= own_in;
            prev_own_ff <= prev_own_in;
            rx_count_ff <= rx_count_in;
            waiting_ff  <= waiting_in;
            idle_ff     <= idle_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && store_we) begin
         rx_store_ff[rx_count_ff] <= item_byte;
      end
   end

endmodule

@@ rtl/llfs_out.sv @@
// result register that plays out one item's run a beat at a time
`timescale 1ns / 1ps

module llfs_out
   import llfs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  run_type     run,
   output logic        run_free,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_out_kind,
   output logic [7:0]  rsp_tx_byte,
   output logic [7:0]  rsp_remote_buttons,
   output logic [7:0]  rsp_frame_number,
   output logic        rsp_last
);

   logic                         lead_pend_ff;
   logic                         pkt_pend_ff;
   logic [1:0]                   byte_idx_ff;
   out_kind_type                 lead_kind_ff;
   logic [7:0]                   lead_buttons_ff;
   logic [PACKET_BYTES-1:0][7:0] pkt_ff;
   logic [7:0]                   frame_ff;
   logic                         beat_done;

   assign rsp_valid = lead_pend_ff | pkt_pend_ff;
   assign rsp_last  = lead_pend_ff ? !pkt_pend_ff : (byte_idx_ff == 2'(PACKET_BYTES - 1));
   assign beat_done = rsp_valid & rsp_ready;
   assign run_free  = !rsp_valid || (rsp_ready && rsp_last);

   assign rsp_out_kind       = lead_pend_ff ? lead_kind_ff : KIND_TX;
   assign rsp_tx_byte        = lead_pend_ff ? 8'd0 : pkt_ff[byte_idx_ff];
   assign rsp_remote_buttons = lead_pend_ff ? lead_buttons_ff : 8'd0;
   assign rsp_frame_number   = frame_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_pend_ff <= 1'b0;
         pkt_pend_ff  <= 1'b0;
         byte_idx_ff  <= 2'd0;
      end else if (load) begin
         lead_pend_ff <= run.has_lead;
         pkt_pend_ff  <= run.has_pkt;
         byte_idx_ff  <= 2'd0;
      end else if (beat_done) begin
         if (lead_pend_ff) begin
            lead_pend_ff <= 1'b0;
         end else begin
            byte_idx_ff <= byte_idx_ff + 2'd1;
            if (rsp_last) begin
               pkt_pend_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lead_kind_ff    <= run.lead_kind;
         lead_buttons_ff <= run.lead_buttons;
         pkt_ff          <= run.pkt;
         frame_ff        <= run.frame;
      end
   end

endmodule

@@ rtl/lockstep_link_frame_sync.sv @@
// top level of the lockstep link frame sync block
`timescale 1ns / 1ps
`include "lockstep_link_frame_sync_defines.svh"

// One end of a lockstep link trading 4-byte packets (start, frame, buttons,
// checksum). A request beat is taken into an input register and decided
// from there once the result register is free; its results then leave on
// the rsp side at one beat per cycle while rsp_ready is high. A beat with no
// result (a dropped or stored byte, a quiet tick) never occupies the result
// register, so such beats go back to back; a beat gives at most five results
// (a checksum error report plus a NACK packet). The next request is accepted
// while the last result of the previous one is still waiting.
// The timeout register may be written on any cycle with csr_wr_en.
module lockstep_link_frame_sync
   import llfs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_rx_byte,
   input  logic [7:0]  req_local_buttons,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_out_kind,
   output logic [7:0]  rsp_tx_byte,
   output logic [7:0]  rsp_remote_buttons,
   output logic [7:0]  rsp_frame_number,
   output logic        rsp_last
);

   logic         in_valid_ff;
   req_kind_type in_type_ff;
   logic [7:0]   in_byte_ff;
   logic [7:0]   in_buttons_ff;
   logic         run_free;
   logic         take;
   logic         run_valid;
   run_type      run;
   logic [17:0]  held_beat;
   logic         err_beat;
   logic         nack_first;

   assign take      = in_valid_ff & run_free;
   assign req_ready = !in_valid_ff || take;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_type_ff    <= req_kind_type'(req_type);
         in_byte_ff    <= req_rx_byte;
         in_buttons_ff <= req_local_buttons;
      end
   end

   llfs_core u_core (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .take         (take),
      .item_type    (in_type_ff),
      .item_byte    (in_byte_ff),
      .item_buttons (in_buttons_ff),
      .run          (run),
      .run_valid    (run_valid)
   );

   llfs_out u_out (
      .clock              (clock),
      .reset              (reset),
      .load               (take & run_valid),
      .run                (run),
      .run_free           (run_free),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_kind       (rsp_out_kind),
      .rsp_tx_byte        (rsp_tx_byte),
      .rsp_remote_buttons (rsp_remote_buttons),
      .rsp_frame_number   (rsp_frame_number),
      .rsp_last           (rsp_last)
   );

   assign held_beat  = {in_type_ff, in_byte_ff, in_buttons_ff};
   assign err_beat   = rsp_valid && rsp_ready && rsp_out_kind == KIND_CSUM_ERR;
   assign nack_first = rsp_valid && rsp_out_kind == KIND_TX && rsp_tx_byte == START_NACK;

   // a held beat waiting on the result side is neither lost nor altered
   `LLFS_ASSERT_NEXT(a_hold_item, in_valid_ff && !take, in_valid_ff && $stable(held_beat))
   // an accepted remote frame is reported on its own
   `LLFS_ASSERT_NOW(a_remote_alone, rsp_valid && rsp_out_kind == KIND_REMOTE, rsp_last)
   // a checksum error is always followed by its NACK packet
   `LLFS_ASSERT_NOW(a_err_then_nack, rsp_valid && rsp_out_kind == KIND_CSUM_ERR, !rsp_last)
   // a checksum error beat is followed at once by the nack start byte
   `LLFS_ASSERT_NEXT(a_pkt_start, err_beat, nack_first)

endmodule
